// ===== src/htd_pkg.sv =====
`timescale 1ns / 1ps

package htd_pkg;

  // Default geometry of the rank table
  localparam int unsigned RankCountDef = 4096;
  localparam int unsigned CoordBitsDef = 5;

  // Widest coordinate the axis arithmetic has to carry
  localparam int unsigned AxisW = 8;

  // Hop counter limit
  localparam logic [5:0] HopMax = 6'd63;

  // Configuration register indexes
  localparam logic [1:0] CfgDimX    = 2'd0;
  localparam logic [1:0] CfgDimY    = 2'd1;
  localparam logic [1:0] CfgDimZ    = 2'd2;
  localparam logic [1:0] CfgMaxRank = 2'd3;

  // Configuration reset values
  localparam logic [5:0]  DimXRst    = 6'd25;
  localparam logic [5:0]  DimYRst    = 6'd32;
  localparam logic [5:0]  DimZRst    = 6'd24;
  localparam logic [11:0] MaxRankRst = 12'd4095;

  // Request kinds
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] rank_a;
    logic [11:0] rank_b;
    logic [30:0] msg_bytes;
    logic [4:0]  node_x;
    logic [4:0]  node_y;
    logic [4:0]  node_z;
    logic        cpu_sel;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  hop_count;
    logic [63:0] total_hops;
    logic [63:0] total_weighted;
    logic        range_error;
  } out_rsp_t;

  // Control from the sequencer to the accumulator
  typedef struct packed {
    logic mul_en;
    logic acc_en;
  } acc_ctrl_t;

  // Shortest wrap-around distance on one axis; no wrap path when the
  // axis size does not exceed the plain distance
  function automatic logic [AxisW-1:0] axis_dist(input logic [AxisW-1:0] a,
                                                 input logic [AxisW-1:0] b,
                                                 input logic [5:0]       size);
    logic [AxisW-1:0] d;
    logic [AxisW-1:0] s;
    logic [AxisW-1:0] w;
    d = (a > b) ? (a - b) : (b - a);
    s = AxisW'(size);
    w = s - d;
    if (s > d) begin
      axis_dist = (w < d) ? w : d;
    end else begin
      axis_dist = d;
    end
  endfunction

endpackage

// ===== src/htd_rank_mem.sv =====
`timescale 1ns / 1ps

module htd_rank_mem #(
  parameter int unsigned RankCount = htd_pkg::RankCountDef,
  parameter int unsigned CoordBits = htd_pkg::CoordBitsDef,
  localparam int unsigned AddrW    = (RankCount > 1) ? $clog2(RankCount) : 1,
  localparam int unsigned EntryW   = 3 * CoordBits + 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [EntryW-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_a_i,
  input  logic [AddrW-1:0]  rd_addr_b_i,
  output logic [EntryW-1:0] rd_data_a_o,
  output logic [EntryW-1:0] rd_data_b_o
);

  logic [EntryW-1:0] mem_q [RankCount];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule

// ===== src/htd_hop_calc.sv =====
`timescale 1ns / 1ps

module htd_hop_calc #(
  parameter int unsigned CoordBits = htd_pkg::CoordBitsDef,
  localparam int unsigned EntryW   = 3 * CoordBits + 1
) (
  input  logic [EntryW-1:0] entry_a_i,
  input  logic [EntryW-1:0] entry_b_i,
  input  logic [5:0]        dim_x_i,
  input  logic [5:0]        dim_y_i,
  input  logic [5:0]        dim_z_i,
  output logic [5:0]        hops_o
);

  logic [CoordBits-1:0] ax, ay, az, bx, by, bz;
  logic                 ca, cb;
  logic [htd_pkg::AxisW-1:0] dx, dy, dz;
  logic [9:0]           sum;

  // Entry layout: {cpu, z, y, x}
  assign ax = entry_a_i[CoordBits-1:0];
  assign ay = entry_a_i[2*CoordBits-1:CoordBits];
  assign az = entry_a_i[3*CoordBits-1:2*CoordBits];
  assign ca = entry_a_i[3*CoordBits];
  assign bx = entry_b_i[CoordBits-1:0];
  assign by = entry_b_i[2*CoordBits-1:CoordBits];
  assign bz = entry_b_i[3*CoordBits-1:2*CoordBits];
  assign cb = entry_b_i[3*CoordBits];

  assign dx = htd_pkg::axis_dist(htd_pkg::AxisW'(ax), htd_pkg::AxisW'(bx), dim_x_i);
  assign dy = htd_pkg::axis_dist(htd_pkg::AxisW'(ay), htd_pkg::AxisW'(by), dim_y_i);
  assign dz = htd_pkg::axis_dist(htd_pkg::AxisW'(az), htd_pkg::AxisW'(bz), dim_z_i);

  assign sum = 10'd2 + 10'(dx) + 10'(dy) + 10'(dz);

  // Same node: 0 hops on the same CPU, 2 across CPUs; else 2 plus the axis distances, saturated at HopMax
  always_comb begin
    if (ax == bx && ay == by && az == bz) begin
      hops_o = (ca == cb) ? 6'd0 : 6'd2;
    end else if (sum > 10'(htd_pkg::HopMax)) begin
      hops_o = htd_pkg::HopMax;
    end else begin
      hops_o = sum[5:0];
    end
  end

endmodule

// ===== src/htd_accum.sv =====
`timescale 1ns / 1ps

module htd_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  htd_pkg::acc_ctrl_t ctrl_i,
  input  logic [5:0]         hops_i,
  input  logic [30:0]        bytes_i,
  input  logic               range_err_i,
  output logic               acc_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output htd_pkg::out_rsp_t  out_rsp_o
);

  logic [36:0]       prod_q;
  logic [63:0]       hop_sum_q, hop_sum_d;
  logic [63:0]       wsum_q, wsum_d;
  logic [64:0]       hop_add, w_add;
  logic              out_valid_q, out_valid_d;
  htd_pkg::out_rsp_t out_rsp_q;

  assign acc_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Weighted term, registered before the add
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= 37'(hops_i) * 37'(bytes_i);
    end
  end

  // Saturating totals
  assign hop_add   = {1'b0, hop_sum_q} + 65'(hops_i);
  assign w_add     = {1'b0, wsum_q} + 65'(prod_q);
  assign hop_sum_d = hop_add[64] ? '1 : hop_add[63:0];
  assign wsum_d    = w_add[64] ? '1 : w_add[63:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.acc_en) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_sum_q   <= '0;
      wsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ctrl_i.acc_en) begin
        hop_sum_q <= hop_sum_d;
        wsum_q    <= wsum_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      out_rsp_q.hop_count      <= hops_i;
      out_rsp_q.total_hops     <= hop_sum_d;
      out_rsp_q.total_weighted <= wsum_d;
      out_rsp_q.range_error    <= range_err_i;
    end
  end

endmodule

// ===== src/torus_hop_distance_engine_core.sv =====
`timescale 1ns / 1ps
// Load requests: written to the rank table at acceptance, no result; one per cycle
//   while no query is in flight. Query requests: table read + hop compute, multiply,
//   accumulate (waits while an earlier result is still untaken); one query in flight.
// A result waiting at the output does not block acceptance of the next request.
// Reset: totals cleared, config registers to defaults; rank table is not cleared.

module torus_hop_distance_engine_core #(
  parameter int unsigned RankCount = htd_pkg::RankCountDef,
  parameter int unsigned CoordBits = htd_pkg::CoordBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  htd_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output htd_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [11:0]       cfg_wdata_i
);

  localparam int unsigned AddrW  = (RankCount > 1) ? $clog2(RankCount) : 1;
  localparam int unsigned EntryW = 3 * CoordBits + 1;

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDist = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StAcc  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [5:0]  dim_x_q, dim_y_q, dim_z_q;
  logic [11:0] max_rank_q;

  logic              accept, is_query;
  logic [20:0]       ra_ext, rb_ext;
  logic              ra_ok, rb_ok, range_err;
  logic [AddrW-1:0]  addr_a, addr_b;
  logic [7:0]        x_ext, y_ext, z_ext;
  logic [EntryW-1:0] wr_entry, entry_a, entry_b;
  logic [5:0]        calc_hops;
  logic              acc_ready;
  htd_pkg::acc_ctrl_t acc_ctrl;

  logic [30:0] bytes_q;
  logic        err_q, same_q;
  logic [5:0]  hops_q;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign is_query   = (in_req_i.kind == htd_pkg::KIND_QUERY);

  // Rank decode and range check
  assign ra_ext    = 21'(in_req_i.rank_a);
  assign rb_ext    = 21'(in_req_i.rank_b);
  assign ra_ok     = ra_ext < 21'(RankCount);
  assign rb_ok     = rb_ext < 21'(RankCount);
  assign addr_a    = ra_ext[AddrW-1:0];
  assign addr_b    = rb_ext[AddrW-1:0];
  assign range_err = (in_req_i.rank_a > max_rank_q) || (in_req_i.rank_b > max_rank_q) ||
                     !ra_ok || !rb_ok;

  // Loaded entry, coordinates cut to CoordBits
  assign x_ext    = 8'(in_req_i.node_x);
  assign y_ext    = 8'(in_req_i.node_y);
  assign z_ext    = 8'(in_req_i.node_z);
  assign wr_entry = {in_req_i.cpu_sel, z_ext[CoordBits-1:0], y_ext[CoordBits-1:0],
                     x_ext[CoordBits-1:0]};

  htd_rank_mem #(
    .RankCount (RankCount),
    .CoordBits (CoordBits)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_en_i     (accept && !is_query && ra_ok),
    .wr_addr_i   (addr_a),
    .wr_data_i   (wr_entry),
    .rd_en_i     (accept && is_query),
    .rd_addr_a_i (addr_a),
    .rd_addr_b_i (addr_b),
    .rd_data_a_o (entry_a),
    .rd_data_b_o (entry_b)
  );

  htd_hop_calc #(
    .CoordBits (CoordBits)
  ) u_calc (
    .entry_a_i (entry_a),
    .entry_b_i (entry_b),
    .dim_x_i   (dim_x_q),
    .dim_y_i   (dim_y_q),
    .dim_z_i   (dim_z_q),
    .hops_o    (calc_hops)
  );

  // Sequencer
  always_comb begin
    state_d         = state_q;
    acc_ctrl.mul_en = 1'b0;
    acc_ctrl.acc_en = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept && is_query) begin
          state_d = StDist;
        end
      end
      StDist: begin
        state_d = StMul;
      end
      StMul: begin
        acc_ctrl.mul_en = 1'b1;
        state_d         = StAcc;
      end
      StAcc: begin
        if (acc_ready) begin
          acc_ctrl.acc_en = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      dim_x_q    <= htd_pkg::DimXRst;
      dim_y_q    <= htd_pkg::DimYRst;
      dim_z_q    <= htd_pkg::DimZRst;
      max_rank_q <= htd_pkg::MaxRankRst;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          htd_pkg::CfgDimX:    dim_x_q    <= cfg_wdata_i[5:0];
          htd_pkg::CfgDimY:    dim_y_q    <= cfg_wdata_i[5:0];
          htd_pkg::CfgDimZ:    dim_z_q    <= cfg_wdata_i[5:0];
          htd_pkg::CfgMaxRank: max_rank_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Query payload held while in flight
  always_ff @(posedge clk_i) begin
    if (accept && is_query) begin
      bytes_q <= in_req_i.msg_bytes;
      err_q   <= range_err;
      same_q  <= (in_req_i.rank_a == in_req_i.rank_b);
    end
    if (state_q == StDist) begin
      hops_q <= (err_q || same_q) ? 6'd0 : calc_hops;
    end
  end

  htd_accum u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (acc_ctrl),
    .hops_i      (hops_q),
    .bytes_i     (bytes_q),
    .range_err_i (err_q),
    .acc_ready_o (acc_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RankCount   = htd_pkg::RankCountDef;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;

  // Node placement of one rank as the predictor keeps it
  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic [4:0] z;
    logic       cpu;
  } node_loc_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  htd_pkg::in_req_t  in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  htd_pkg::out_rsp_t out_rsp_o;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_idx_i   = htd_pkg::CfgDimX;
  logic [11:0]       cfg_wdata_i = '0;

  // Requests waiting for the driver, responses waiting for the DUT
  htd_pkg::in_req_t  req_pend_q[$];
  htd_pkg::out_rsp_t hop_rsp_q[$];

  // Predictor state: rank placement, geometry shadow, running totals
  node_loc_t   rank_loc[RankCount];
  logic [5:0]  geo_dim_x    = htd_pkg::DimXRst;
  logic [5:0]  geo_dim_y    = htd_pkg::DimYRst;
  logic [5:0]  geo_dim_z    = htd_pkg::DimZRst;
  logic [11:0] geo_max_rank = htd_pkg::MaxRankRst;
  logic [63:0] hop_total      = '0;
  logic [63:0] byte_hop_total = '0;

  // Generator bookkeeping: queries only name ranks that were loaded
  bit          rank_loaded[RankCount];
  int unsigned loaded_ranks[$];
  node_loc_t   recent_loc = '0;

  bit          no_idle     = 1'b0;
  int unsigned in_gap      = 0;
  int unsigned out_stall   = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_cnt     = 0;

  torus_hop_distance_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Shortest way around one ring; no wrap when the ring is not longer than the gap
  function automatic int unsigned wrap_dist(input int unsigned a, input int unsigned b,
                                            input int unsigned size);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    if (size > d) return (size - d < d) ? size - d : d;
    return d;
  endfunction

  function automatic logic [5:0] hop_distance(input node_loc_t a, input node_loc_t b);
    int unsigned h;
    if (a.x == b.x && a.y == b.y && a.z == b.z) return (a.cpu == b.cpu) ? 6'd0 : 6'd2;
    h = 2 + wrap_dist(32'(a.x), 32'(b.x), 32'(geo_dim_x))
          + wrap_dist(32'(a.y), 32'(b.y), 32'(geo_dim_y))
          + wrap_dist(32'(a.z), 32'(b.z), 32'(geo_dim_z));
    return (h > 32'(htd_pkg::HopMax)) ? htd_pkg::HopMax : h[5:0];
  endfunction

  // Apply one accepted request to the predictor
  task automatic predict_request(input htd_pkg::in_req_t r);
    htd_pkg::out_rsp_t rsp;
    logic [5:0]        hops;
    if (r.kind == htd_pkg::KIND_LOAD) begin
      rank_loc[r.rank_a] = '{x: r.node_x, y: r.node_y, z: r.node_z, cpu: r.cpu_sel};
    end else if (r.rank_a > geo_max_rank || r.rank_b > geo_max_rank) begin
      // either rank out of range: flagged, totals untouched
      rsp = '{hop_count: '0, total_hops: hop_total, total_weighted: byte_hop_total,
              range_error: 1'b1};
      hop_rsp_q = {hop_rsp_q, rsp};
    end else begin
      if (r.rank_a == r.rank_b) hops = '0;
      else hops = hop_distance(rank_loc[r.rank_a], rank_loc[r.rank_b]);
      hop_total      = sat_add64(hop_total, 64'(hops));
      byte_hop_total = sat_add64(byte_hop_total, 64'(hops) * 64'(r.msg_bytes));
      rsp = '{hop_count: hops, total_hops: hop_total, total_weighted: byte_hop_total,
              range_error: 1'b0};
      hop_rsp_q = {hop_rsp_q, rsp};
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic check_result(input htd_pkg::out_rsp_t got);
    htd_pkg::out_rsp_t want;
    if (hop_rsp_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MaxReports) $display("unexpected response %h", got);
    end else begin
      want = hop_rsp_q.pop_front();
      check_field("hop_count", 64'(want.hop_count), 64'(got.hop_count));
      check_field("total_hops", want.total_hops, got.total_hops);
      check_field("total_weighted", want.total_weighted, got.total_weighted);
      check_field("range_error", 64'(want.range_error), 64'(got.range_error));
    end
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (req_pend_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= req_pend_q.pop_front();
        in_gap     <= no_idle ? 0 : rand_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_stall != 0) begin
      out_ready_i <= 1'b0;
      out_stall   <= out_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!no_idle && $urandom_range(0, 4) == 0) out_stall <= rand_gap();
    end
  end

  // Monitor: check responses, predict from accepted requests, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_rsp_o);
      if (in_valid_i && in_ready_o) predict_request(in_req_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_load(input int unsigned rank, input int unsigned x,
                           input int unsigned y, input int unsigned z,
                           input int unsigned cpu);
    htd_pkg::in_req_t r;
    r.kind      = htd_pkg::KIND_LOAD;
    r.rank_a    = 12'(rank);
    r.rank_b    = 12'($urandom);
    r.msg_bytes = 31'($urandom);
    r.node_x    = 5'(x);
    r.node_y    = 5'(y);
    r.node_z    = 5'(z);
    r.cpu_sel   = 1'(cpu);
    req_pend_q = {req_pend_q, r};
    recent_loc = '{x: r.node_x, y: r.node_y, z: r.node_z, cpu: r.cpu_sel};
    if (!rank_loaded[rank]) begin
      rank_loaded[rank] = 1'b1;
      loaded_ranks = {loaded_ranks, rank};
    end
  endtask

  task automatic push_query(input int unsigned ra, input int unsigned rb,
                            input logic [30:0] bytes);
    htd_pkg::in_req_t r;
    r.kind      = htd_pkg::KIND_QUERY;
    r.rank_a    = 12'(ra);
    r.rank_b    = 12'(rb);
    r.msg_bytes = bytes;
    r.node_x    = 5'($urandom);
    r.node_y    = 5'($urandom);
    r.node_z    = 5'($urandom);
    r.cpu_sel   = 1'($urandom);
    req_pend_q = {req_pend_q, r};
  endtask

  // Coordinate mostly inside the ring, sometimes anywhere in the field
  function automatic int unsigned rand_coord(input logic [5:0] dim);
    if (dim != 0 && $urandom_range(0, 9) < 6) return $urandom_range(0, 32'(dim) - 1);
    return $urandom_range(0, 31);
  endfunction

  task automatic push_random_load();
    int unsigned rank;
    if (loaded_ranks.size() != 0 && $urandom_range(0, 9) < 3)
      rank = loaded_ranks[$urandom_range(0, loaded_ranks.size() - 1)];
    else
      rank = $urandom_range(0, RankCount - 1);
    // reuse a recent node now and then so same-node pairs show up
    if ($urandom_range(0, 9) < 3)
      push_load(rank, 32'(recent_loc.x), 32'(recent_loc.y), 32'(recent_loc.z),
                $urandom_range(0, 1));
    else
      push_load(rank, rand_coord(geo_dim_x), rand_coord(geo_dim_y), rand_coord(geo_dim_z),
                $urandom_range(0, 1));
  endtask

  task automatic push_random_query();
    int unsigned ra;
    int unsigned rb;
    int unsigned sel;
    logic [30:0] bytes;
    ra = loaded_ranks[$urandom_range(0, loaded_ranks.size() - 1)];
    if ($urandom_range(0, 9) == 0) rb = ra;
    else rb = loaded_ranks[$urandom_range(0, loaded_ranks.size() - 1)];
    sel = $urandom_range(0, 9);
    if (sel == 0) bytes = '0;
    else if (sel == 1) bytes = '1;
    else bytes = 31'($urandom);
    push_query(ra, rb, bytes);
  endtask

  // Wait until nothing is queued, offered or outstanding
  task automatic drain();
    do @(negedge clk_i);
    while (req_pend_q.size() != 0 || in_valid_i || hop_rsp_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= 12'(val);
  endtask

  task automatic set_geometry(input int unsigned dx, input int unsigned dy,
                              input int unsigned dz, input int unsigned mr);
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(htd_pkg::CfgDimX, dx);
    write_reg(htd_pkg::CfgDimY, dy);
    write_reg(htd_pkg::CfgDimZ, dz);
    write_reg(htd_pkg::CfgMaxRank, mr);
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    geo_dim_x    = 6'(dx);
    geo_dim_y    = 6'(dy);
    geo_dim_z    = 6'(dz);
    geo_max_rank = 12'(mr);
  endtask

  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        while (req_pend_q.size() > 4) @(posedge clk_i);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      // hold the sender until the pipe is empty once per phase
      if (i == n / 2) drain();
      if (loaded_ranks.size() == 0 || $urandom_range(0, 9) < 4) push_random_load();
      else push_random_query();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset geometry, corner placements
    push_load(0, 0, 0, 0, 0);
    push_load(4095, 31, 31, 31, 1);
    push_load(1, 0, 0, 0, 1);
    push_load(2, 0, 0, 0, 0);
    push_load(3, 12, 16, 12, 0);
    push_load(2048, 24, 31, 23, 0);
    push_load(12'h555, 10, 21, 10, 1);
    push_load(12'hAAA, 21, 10, 21, 0);
    push_query(0, 0, 31'h7FFF_FFFF);       // same rank
    push_query(0, 2, 31'h7FFF_FFFF);       // same node, same CPU
    push_query(0, 1, 31'h7FFF_FFFF);       // same node, other CPU
    push_query(0, 3, 31'h7FFF_FFFF);       // half-ring distances
    push_query(0, 2048, 31'h1234_5678);    // one step via wrap on each axis
    push_query(0, 4095, 31'h7FFF_FFFF);    // x and z coords past ring size, hop clamp
    push_query(12'h555, 12'hAAA, '0);
    push_query(4095, 0, 31'($urandom));

    // Directed: rank range check on either side
    set_geometry(32'(htd_pkg::DimXRst), 32'(htd_pkg::DimYRst), 32'(htd_pkg::DimZRst),
                 2047);
    push_query(0, 4095, 31'h7FFF_FFFF);
    push_query(4095, 0, 31'h7FFF_FFFF);
    push_query(4095, 4095, 31'h7FFF_FFFF);

    // Directed: smallest rings, no wrap path anywhere
    set_geometry(1, 1, 1, 4095);
    push_query(0, 4095, 31'h7FFF_FFFF);
    push_query(0, 3, 31'h7FFF_FFFF);

    // Random phases over a spread of geometries
    set_geometry(32, 32, 32, 4095);
    run_random(100);
    set_geometry($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
                 $urandom_range(1024, 4095));
    run_random(100);
    set_geometry(0, $urandom_range(1, 32), 1, 4095);
    run_random(100);
    set_geometry($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32), 0);
    run_random(60);
    set_geometry($urandom_range(0, 32), $urandom_range(0, 32), $urandom_range(0, 32),
                 $urandom_range(0, 4095));
    run_random(100);
    set_geometry(32'(htd_pkg::DimXRst), 32'(htd_pkg::DimYRst), 32'(htd_pkg::DimZRst),
                 32'(htd_pkg::MaxRankRst));
    run_random(140);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && hop_rsp_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
